[hw/rtl/pressure_temperature_compensation_core_defines.svh]
// Assertion macros shared by the compensation core.
// Included by files that carry concurrent assertions; no other dependencies.
`ifndef PRESSURE_TEMPERATURE_COMPENSATION_CORE_DEFINES_SVH
`define PRESSURE_TEMPERATURE_COMPENSATION_CORE_DEFINES_SVH

// Same-cycle implication, disabled during reset.
`define PTC_ASSERT_IMP(lbl, clk, rst_n, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication, disabled during reset.
`define PTC_ASSERT_NXT(lbl, clk, rst_n, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

[hw/rtl/ptc_pkg.sv]
// Widths, constants and types of the pressure/temperature compensation core.
// No dependencies; imported by ptc_div, ptc_mulq and the top level.
package ptc_pkg;

    // input and scaled-raw formats
    localparam int RAW_W     = 24;
    localparam int SCALE_W   = 23;
    localparam int SC_W      = 29;          // Q5.24
    localparam int SC_FRAC   = 24;

    // divider: overflow bit plus SC_W quotient bits, one per stage
    localparam int DIV_STEPS = SC_W + 1;
    localparam int DIV_D_W   = SCALE_W + 1;
    localparam int DIV_M_W   = RAW_W + SCALE_W + 2;
    localparam int DIV_C_W   = DIV_D_W + DIV_STEPS - 1;
    localparam int DIV_LAT   = DIV_STEPS + 2;

    // split multiply with rounding back to work fraction
    localparam int MQ_A_W    = 42;
    localparam int MQ_SPLIT  = 21;
    localparam int MQ_R_W    = 48;
    localparam int MQ_P_W    = MQ_A_W + SC_W;
    localparam int MQ_FRAC   = SC_FRAC;
    localparam int POST_LAT  = 6;
    localparam int VLD_LEN   = DIV_LAT + POST_LAT;

    // work values and result formats
    localparam int PW_FRAC    = 16;
    localparam int PRESS_FRAC = 6;
    localparam int P_SHIFT    = PW_FRAC - PRESS_FRAC;
    localparam int P_SH_W     = MQ_R_W - P_SHIFT;
    localparam int TEMP_FRAC  = 8;
    localparam int T_SHIFT    = SC_FRAC - TEMP_FRAC;
    localparam int C0_SHIFT   = TEMP_FRAC - 1;
    localparam int PRESS_W    = 32;
    localparam int TEMP_W     = 24;
    localparam int T_SUM_W    = 26;

    // coefficient and register widths
    localparam int C_T_W     = 12;
    localparam int C_PO_W    = 20;
    localparam int C_PM_W    = 16;
    localparam int CT_W      = C_T_W + SC_W;
    localparam int TCOEF_W   = 2 * C_T_W;
    localparam int POFF_W    = 2 * C_PO_W;
    localparam int PMID_W    = 3 * C_PM_W;
    localparam int PHIGH_W   = 2 * C_PM_W;
    localparam int CFG_W     = 48;
    localparam int CFG_IDX_W = 3;

    localparam logic [SCALE_W-1:0] SCALE_RST = 23'd524288;

    localparam logic signed [SC_W-1:0] SC_MAX = {1'b0, {(SC_W-1){1'b1}}};
    localparam logic signed [SC_W-1:0] SC_MIN = {1'b1, {(SC_W-1){1'b0}}};
    localparam logic signed [PRESS_W-1:0] PRESS_MAX = {1'b0, {(PRESS_W-1){1'b1}}};
    localparam logic signed [PRESS_W-1:0] PRESS_MIN = {1'b1, {(PRESS_W-1){1'b0}}};
    localparam logic signed [TEMP_W-1:0] TEMP_MAX = {1'b0, {(TEMP_W-1){1'b1}}};
    localparam logic signed [TEMP_W-1:0] TEMP_MIN = {1'b1, {(TEMP_W-1){1'b0}}};

    // -1.0 Pa and -1.0 degC in output units
    localparam logic signed [PRESS_W-1:0] PRESS_NOT_READY = -32'sd64;
    localparam logic signed [TEMP_W-1:0]  TEMP_NOT_READY  = -24'sd256;

    typedef enum logic [CFG_IDX_W-1:0] {
        CFG_TEMP_COEF    = 3'd0,
        CFG_PRESS_OFFSET = 3'd1,
        CFG_PRESS_MID    = 3'd2,
        CFG_PRESS_HIGH   = 3'd3,
        CFG_TEMP_SCALE   = 3'd4,
        CFG_PRESS_SCALE  = 3'd5
    } t_cfg_idx;

endpackage

[hw/rtl/ptc_div.sv]
// Pipelined restoring divider: round(raw * 2^24 / scale) saturated to Q5.24.
// Depends on ptc_pkg. The pipeline advances when i_en is high.
module ptc_div
    import ptc_pkg::*;
(
    input  logic                     i_clk,
    input  logic                     i_en,
    input  logic signed [RAW_W-1:0]  i_raw,
    input  logic [SCALE_W-1:0]       i_scale,
    output logic signed [SC_W-1:0]   o_q
);

    logic [SCALE_W-1:0]  w_d;
    logic [DIV_D_W-1:0]  w_dd;
    logic                w_neg;
    logic [RAW_W-1:0]    w_abs;
    logic [SCALE_W-1:0]  w_low;
    logic [DIV_M_W-1:0]  w_m;

    logic [DIV_M_W-1:0]   r_rem [0:DIV_STEPS];
    logic [DIV_STEPS-1:0] r_qb  [0:DIV_STEPS];
    logic                 r_neg [0:DIV_STEPS];

    logic [DIV_STEPS-1:0]    w_qf;
    logic [SC_W-1:0]         w_mag;
    logic                    w_ovf;
    logic signed [SC_W-1:0]  n_quot;
    logic signed [SC_W-1:0]  r_quot;

    // floor((raw*2^25 + d) / 2d): fold the sign into the dividend so the
    // steps work on magnitudes; for negative raw the dividend becomes
    // |raw|*2^25 + d - 1 (ceil of the magnitude).
    always_comb begin
        w_d   = (i_scale == '0) ? SCALE_W'(1) : i_scale;
        w_dd  = {w_d, 1'b0};
        w_neg = i_raw[RAW_W-1];
        w_abs = w_neg ? (~i_raw + 1'b1) : i_raw;
        w_low = w_neg ? (w_d - 1'b1) : w_d;
        w_m   = {w_abs, 2'b00, w_low};
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_rem[0] <= w_m;
            r_qb[0]  <= '0;
            r_neg[0] <= w_neg;
        end
    end

    // divisor must be held static while items are in flight; not enforced here
    for (genvar s = 0; s < DIV_STEPS; s++) begin : g_step
        localparam int K = DIV_STEPS - 1 - s;
        logic [DIV_C_W-1:0] w_rem_x;
        logic [DIV_C_W-1:0] w_dsh;
        logic [DIV_C_W-1:0] w_diff;
        logic               w_ge;

        always_comb begin
            w_rem_x = DIV_C_W'(r_rem[s]);
            w_dsh   = DIV_C_W'(w_dd) << K;
            w_diff  = w_rem_x - w_dsh;
            w_ge    = (w_rem_x >= w_dsh);
        end

        always_ff @(posedge i_clk) begin
            if (i_en) begin
                r_rem[s+1] <= w_ge ? w_diff[DIV_M_W-1:0] : r_rem[s];
                r_qb[s+1]  <= {r_qb[s][DIV_STEPS-2:0], w_ge};
                r_neg[s+1] <= r_neg[s];
            end
        end
    end

    // top quotient bit flags overflow; later bits are then meaningless
    always_comb begin
        w_qf  = r_qb[DIV_STEPS];
        w_ovf = w_qf[DIV_STEPS-1];
        w_mag = w_qf[SC_W-1:0];
        if (!r_neg[DIV_STEPS]) begin
            n_quot = (w_ovf || w_mag[SC_W-1]) ? SC_MAX : $signed(w_mag);
        end else begin
            n_quot = (w_ovf || (w_mag[SC_W-1] && (|w_mag[SC_W-2:0])))
                   ? SC_MIN : -$signed(w_mag);
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_quot <= n_quot;
        end
    end

    assign o_q = r_quot;

endmodule

[hw/rtl/ptc_mulq.sv]
// Two-stage multiply of a work value by a Q5.24 value, rounded to work fraction.
// Depends on ptc_pkg. o_r = floor((a*s + 2^23) / 2^24) + add; add held static.
module ptc_mulq
    import ptc_pkg::*;
(
    input  logic                      i_clk,
    input  logic                      i_en,
    input  logic signed [MQ_A_W-1:0]  i_a,
    input  logic signed [SC_W-1:0]    i_s,
    input  logic signed [MQ_R_W-1:0]  i_add,
    output logic signed [MQ_R_W-1:0]  o_r
);

    logic signed [MQ_A_W-MQ_SPLIT+SC_W-1:0] r_pp_hi;
    logic signed [MQ_SPLIT+SC_W:0]          r_pp_lo;
    logic signed [MQ_P_W-1:0]               w_prod;
    logic signed [MQ_R_W-1:0]               n_r;
    logic signed [MQ_R_W-1:0]               r_r;

    // partial products (signed upper half, unsigned lower half) and the result
    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_pp_hi <= $signed(i_a[MQ_A_W-1:MQ_SPLIT]) * i_s;
            r_pp_lo <= $signed({1'b0, i_a[MQ_SPLIT-1:0]}) * i_s;
            r_r     <= n_r;
        end
    end

    always_comb begin
        w_prod = (MQ_P_W'(r_pp_hi) <<< MQ_SPLIT) + MQ_P_W'(r_pp_lo)
               + (MQ_P_W'(1) <<< (MQ_FRAC - 1));
        n_r    = MQ_R_W'($signed(w_prod[MQ_P_W-1:MQ_FRAC])) + i_add;
    end

    assign o_r = r_r;

endmodule

[hw/rtl/pressure_temperature_compensation_core.sv]
// Top level of the barometric pressure / temperature compensation core.
// Depends on ptc_pkg, ptc_div, ptc_mulq and the assertion macro header.
`include "pressure_temperature_compensation_core_defines.svh"

// Takes one reading per clock while ready is high and returns one result per
// reading, in order. The beat passes 40 registers, the first loaded at the
// accepting edge: 32 for the two parallel restoring dividers (a prep stage, 30
// one-bit steps covering the 29-bit Q5.24 quotient plus overflow, a saturate
// stage), six for the three Horner steps of the pressure polynomial (each a
// 42x29 multiply split into two partial products, then a rounding add), one to
// round and saturate, and the output register. An output register plus a
// one-entry skid buffer let the pipeline keep running while a result waits;
// ready drops only when both are full. Configuration writes take effect at once
// and must only be made while no reading is in flight. Pressure is in 1/64 Pa,
// temperature in 1/256 degC.
module pressure_temperature_compensation_core
    import ptc_pkg::*;
(
    input  logic                       i_clk,
    input  logic                       i_rst_n,
    input  logic                       i_cfg_we,
    input  logic [CFG_IDX_W-1:0]       i_cfg_idx,
    input  logic [CFG_W-1:0]           i_cfg_data,
    input  logic                       i_in_valid,
    output logic                       o_in_ready,
    input  logic signed [RAW_W-1:0]    i_raw_pressure,
    input  logic signed [RAW_W-1:0]    i_raw_temperature,
    input  logic                       i_data_ready,
    output logic                       o_out_valid,
    input  logic                       i_out_ready,
    output logic signed [PRESS_W-1:0]  o_pressure_out,
    output logic signed [TEMP_W-1:0]   o_temperature_out,
    output logic                       o_result_valid
);

    typedef struct packed {
        logic signed [PRESS_W-1:0] press;
        logic signed [TEMP_W-1:0]  temp;
        logic                      flag;
    } t_result;

    // configuration
    logic [TCOEF_W-1:0]  r_temp_coef;
    logic [POFF_W-1:0]   r_press_off;
    logic [PMID_W-1:0]   r_press_mid;
    logic [PHIGH_W-1:0]  r_press_high;
    logic [SCALE_W-1:0]  r_temp_scale;
    logic [SCALE_W-1:0]  r_press_scale;

    logic signed [C_T_W-1:0]  w_c0, w_c1;
    logic signed [C_PO_W-1:0] w_c00, w_c10;
    logic signed [C_PM_W-1:0] w_c01, w_c11, w_c20, w_c21, w_c30;

    // pipeline control
    logic w_en;
    logic r_vld  [0:VLD_LEN-1];
    logic r_flag [0:VLD_LEN-1];

    // datapath
    logic signed [SC_W-1:0]   w_psc, w_tsc;
    logic signed [SC_W-1:0]   r_psc_d [1:4];
    logic signed [SC_W-1:0]   r_tsc_d [1:4];
    logic signed [MQ_R_W-1:0] w_t1, w_u1, w_t2, w_u2, w_t3, w_v;
    logic signed [CT_W-1:0]   r_ct;
    logic signed [CT_W-1:0]   w_ct_r;
    logic signed [T_SUM_W-1:0] w_t_sum;
    logic signed [TEMP_W-1:0] n_tval, r_tval;
    logic signed [MQ_R_W-1:0] w_p_sum;
    logic signed [P_SH_W-1:0] w_p_sh;
    logic signed [PRESS_W-1:0] w_p_sat;

    // final stage, output register, skid
    logic    r_fin_vld;
    t_result n_fin, r_fin;
    logic    r_out_valid, r_skd_valid;
    t_result r_out, r_skd;

    // ---------------- configuration ----------------
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_temp_coef   <= '0;
            r_press_off   <= '0;
            r_press_mid   <= '0;
            r_press_high  <= '0;
            r_temp_scale  <= SCALE_RST;
            r_press_scale <= SCALE_RST;
        end else if (i_cfg_we) begin
            unique case (t_cfg_idx'(i_cfg_idx))
                CFG_TEMP_COEF:    r_temp_coef   <= i_cfg_data[TCOEF_W-1:0];
                CFG_PRESS_OFFSET: r_press_off   <= i_cfg_data[POFF_W-1:0];
                CFG_PRESS_MID:    r_press_mid   <= i_cfg_data[PMID_W-1:0];
                CFG_PRESS_HIGH:   r_press_high  <= i_cfg_data[PHIGH_W-1:0];
                CFG_TEMP_SCALE:   r_temp_scale  <= i_cfg_data[SCALE_W-1:0];
                CFG_PRESS_SCALE:  r_press_scale <= i_cfg_data[SCALE_W-1:0];
                default: ;
            endcase
        end
    end

    always_comb begin
        w_c0  = $signed(r_temp_coef[2*C_T_W-1:C_T_W]);
        w_c1  = $signed(r_temp_coef[C_T_W-1:0]);
        w_c00 = $signed(r_press_off[2*C_PO_W-1:C_PO_W]);
        w_c10 = $signed(r_press_off[C_PO_W-1:0]);
        w_c01 = $signed(r_press_mid[3*C_PM_W-1:2*C_PM_W]);
        w_c11 = $signed(r_press_mid[2*C_PM_W-1:C_PM_W]);
        w_c20 = $signed(r_press_mid[C_PM_W-1:0]);
        w_c21 = $signed(r_press_high[2*C_PM_W-1:C_PM_W]);
        w_c30 = $signed(r_press_high[C_PM_W-1:0]);
    end

    // ---------------- pipeline control ----------------
    assign w_en       = !r_skd_valid;
    assign o_in_ready = w_en;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            for (int i = 0; i < VLD_LEN; i++) begin
                r_vld[i] <= 1'b0;
            end
            r_fin_vld <= 1'b0;
        end else if (w_en) begin
            r_vld[0] <= i_in_valid;
            for (int i = 1; i < VLD_LEN; i++) begin
                r_vld[i] <= r_vld[i-1];
            end
            r_fin_vld <= r_vld[VLD_LEN-1];
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_en) begin
            r_flag[0] <= i_data_ready;
            for (int i = 1; i < VLD_LEN; i++) begin
                r_flag[i] <= r_flag[i-1];
            end
        end
    end

    // ---------------- scaling ----------------
    ptc_div u_div_p (
        .i_clk   (i_clk),
        .i_en    (w_en),
        .i_raw   (i_raw_pressure),
        .i_scale (r_press_scale),
        .o_q     (w_psc)
    );

    ptc_div u_div_t (
        .i_clk   (i_clk),
        .i_en    (w_en),
        .i_raw   (i_raw_temperature),
        .i_scale (r_temp_scale),
        .o_q     (w_tsc)
    );

    always_ff @(posedge i_clk) begin
        if (w_en) begin
            r_psc_d[1] <= w_psc;
            r_tsc_d[1] <= w_tsc;
            for (int i = 2; i <= 4; i++) begin
                r_psc_d[i] <= r_psc_d[i-1];
                r_tsc_d[i] <= r_tsc_d[i-1];
            end
        end
    end

    // ---------------- pressure polynomial, Horner order ----------------
    ptc_mulq u_mq_t1 (
        .i_clk (i_clk),
        .i_en  (w_en),
        .i_a   (MQ_A_W'(w_c30) <<< PW_FRAC),
        .i_s   (w_psc),
        .i_add (MQ_R_W'(w_c20) <<< PW_FRAC),
        .o_r   (w_t1)
    );

    ptc_mulq u_mq_u1 (
        .i_clk (i_clk),
        .i_en  (w_en),
        .i_a   (MQ_A_W'(w_c21) <<< PW_FRAC),
        .i_s   (w_psc),
        .i_add (MQ_R_W'(w_c11) <<< PW_FRAC),
        .o_r   (w_u1)
    );

    ptc_mulq u_mq_t2 (
        .i_clk (i_clk),
        .i_en  (w_en),
        .i_a   (MQ_A_W'(w_t1)),
        .i_s   (r_psc_d[2]),
        .i_add (MQ_R_W'(w_c10) <<< PW_FRAC),
        .o_r   (w_t2)
    );

    ptc_mulq u_mq_u2 (
        .i_clk (i_clk),
        .i_en  (w_en),
        .i_a   (MQ_A_W'(w_u1)),
        .i_s   (r_psc_d[2]),
        .i_add (MQ_R_W'(w_c01) <<< PW_FRAC),
        .o_r   (w_u2)
    );

    ptc_mulq u_mq_t3 (
        .i_clk (i_clk),
        .i_en  (w_en),
        .i_a   (MQ_A_W'(w_t2)),
        .i_s   (r_psc_d[4]),
        .i_add (MQ_R_W'(w_c00) <<< PW_FRAC),
        .o_r   (w_t3)
    );

    // output rounding constant rides along with the temperature term
    ptc_mulq u_mq_v (
        .i_clk (i_clk),
        .i_en  (w_en),
        .i_a   (MQ_A_W'(w_u2)),
        .i_s   (r_tsc_d[4]),
        .i_add (MQ_R_W'(1) <<< (P_SHIFT - 1)),
        .o_r   (w_v)
    );

    // ---------------- temperature ----------------
    always_comb begin
        w_ct_r  = r_ct + (CT_W'(1) <<< (T_SHIFT - 1));
        w_t_sum = T_SUM_W'($signed(w_ct_r[CT_W-1:T_SHIFT]))
                + (T_SUM_W'(w_c0) <<< C0_SHIFT);
        if (w_t_sum > T_SUM_W'(TEMP_MAX)) begin
            n_tval = TEMP_MAX;
        end else if (w_t_sum < T_SUM_W'(TEMP_MIN)) begin
            n_tval = TEMP_MIN;
        end else begin
            n_tval = TEMP_W'(w_t_sum);
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_en) begin
            r_ct   <= w_c1 * r_tsc_d[4];
            r_tval <= n_tval;
        end
    end

    // ---------------- final round, saturate, not-ready substitution ----------------
    always_comb begin
        w_p_sum = w_t3 + w_v;
        w_p_sh  = $signed(w_p_sum[MQ_R_W-1:P_SHIFT]);
        if (w_p_sh > P_SH_W'(PRESS_MAX)) begin
            w_p_sat = PRESS_MAX;
        end else if (w_p_sh < P_SH_W'(PRESS_MIN)) begin
            w_p_sat = PRESS_MIN;
        end else begin
            w_p_sat = PRESS_W'(w_p_sh);
        end
        n_fin.flag  = r_flag[VLD_LEN-1];
        n_fin.press = r_flag[VLD_LEN-1] ? w_p_sat : PRESS_NOT_READY;
        n_fin.temp  = r_flag[VLD_LEN-1] ? r_tval : TEMP_NOT_READY;
    end

    always_ff @(posedge i_clk) begin
        if (w_en) begin
            r_fin <= n_fin;
        end
    end

    // ---------------- output register and skid ----------------
    // the pipeline runs whenever the skid is empty, so a finished beat in
    // r_fin must land in the output register or, if that one is held, the skid
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
            r_skd_valid <= 1'b0;
        end else if (r_skd_valid) begin
            if (i_out_ready) begin
                r_skd_valid <= 1'b0;
            end
        end else if (!r_out_valid || i_out_ready) begin
            r_out_valid <= r_fin_vld;
        end else if (r_fin_vld) begin
            r_skd_valid <= 1'b1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (r_skd_valid) begin
            if (i_out_ready) begin
                r_out <= r_skd;
            end
        end else if (!r_out_valid || i_out_ready) begin
            r_out <= r_fin;
        end else begin
            r_skd <= r_fin;
        end
    end

    assign o_out_valid       = r_out_valid;
    assign o_pressure_out    = r_out.press;
    assign o_temperature_out = r_out.temp;
    assign o_result_valid    = r_out.flag;

    // ---------------- assertions ----------------
    `PTC_ASSERT_IMP(a_skid_needs_out, i_clk, i_rst_n, r_skd_valid, r_out_valid,
                    "skid full with empty output register")
    `PTC_ASSERT_NXT(a_held_beat_to_skid, i_clk, i_rst_n,
                    !r_skd_valid && r_fin_vld && r_out_valid && !i_out_ready,
                    r_skd_valid, "finished beat not caught by skid")
    `PTC_ASSERT_IMP(a_not_ready_values, i_clk, i_rst_n, o_out_valid && !o_result_valid,
                    o_pressure_out == PRESS_NOT_READY && o_temperature_out == TEMP_NOT_READY,
                    "not-ready result carries wrong values")

endmodule

[sim/tb_pressure_temperature_compensation_core.sv]
// Testbench for pressure_temperature_compensation_core: directed and random readings
// are checked beat by beat against a fixed-point predictor kept in this file.
// Depends on ptc_pkg and the core RTL.
module tb_pressure_temperature_compensation_core
    import ptc_pkg::*;
();

    timeunit 1ns;
    timeprecision 1ps;

    localparam int  MAX_REPORTS = 10;
    localparam int  DRAIN_WAIT  = 60;
    localparam time TIMEOUT_NS  = 2_000_000;

    localparam logic [CFG_IDX_W-1:0] CFG_IDX_SPARE_A = 3'd6;
    localparam logic [CFG_IDX_W-1:0] CFG_IDX_SPARE_B = 3'd7;

    localparam logic signed [RAW_W-1:0] RAW_MAX = {1'b0, {(RAW_W-1){1'b1}}};
    localparam logic signed [RAW_W-1:0] RAW_MIN = {1'b1, {(RAW_W-1){1'b0}}};
    localparam logic [SCALE_W-1:0]      SCALE_MAX = '1;

    // oversampling scale factors of the sensor family
    localparam logic [SCALE_W-1:0] OSR_SCALES [8] = '{
        23'd524288, 23'd1572864, 23'd3670016, 23'd7864320,
        23'd253952, 23'd516096, 23'd1040384, 23'd2088960
    };

    typedef logic signed [95:0] t_acc;

    typedef struct packed {
        logic signed [PRESS_W-1:0] pressure;
        logic signed [TEMP_W-1:0]  temperature;
        logic                      valid;
    } t_reading;

    logic                      clk = 1'b0;
    logic                      rst_n;
    logic                      cfg_we;
    logic [CFG_IDX_W-1:0]      cfg_idx;
    logic [CFG_W-1:0]          cfg_data;
    logic                      reading_valid;
    logic                      reading_accept;
    logic signed [RAW_W-1:0]   raw_press;
    logic signed [RAW_W-1:0]   raw_temp;
    logic                      reading_rdy;
    logic                      result_out_valid;
    logic                      result_ready = 1'b0;
    logic signed [PRESS_W-1:0] press_out;
    logic signed [TEMP_W-1:0]  temp_out;
    logic                      result_flag;

    // predictor copy of the calibration registers
    logic [TCOEF_W-1:0] coef_temp;
    logic [POFF_W-1:0]  coef_press_offset;
    logic [PMID_W-1:0]  coef_press_mid;
    logic [PHIGH_W-1:0] coef_press_high;
    logic [SCALE_W-1:0] scale_temp;
    logic [SCALE_W-1:0] scale_press;

    t_reading pending_readings[$];
    int       fault_count     = 0;
    int       send_idle_pct   = 0;
    int       recv_stall_pct  = 0;

    pressure_temperature_compensation_core u_dut (
        .i_clk            (clk),
        .i_rst_n          (rst_n),
        .i_cfg_we         (cfg_we),
        .i_cfg_idx        (cfg_idx),
        .i_cfg_data       (cfg_data),
        .i_in_valid       (reading_valid),
        .o_in_ready       (reading_accept),
        .i_raw_pressure   (raw_press),
        .i_raw_temperature(raw_temp),
        .i_data_ready     (reading_rdy),
        .o_out_valid      (result_out_valid),
        .i_out_ready      (result_ready),
        .o_pressure_out   (press_out),
        .o_temperature_out(temp_out),
        .o_result_valid   (result_flag)
    );

    always begin
        #6 clk = 1'b1;
        #6 clk = 1'b0;
    end

    initial begin
        #(TIMEOUT_NS);
        $display("Test completed with failures");
        $finish;
    end

    // ---------------------------------------------------------------- predictor

    function automatic t_acc floor_div(t_acc num, t_acc den);
        if (num >= 0) return num / den;
        return -((-num + den - 1) / den);
    endfunction

    function automatic t_acc clamp(t_acc v, t_acc lo, t_acc hi);
        return (v < lo) ? lo : ((v > hi) ? hi : v);
    endfunction

    // raw / scale in Q5.24, ties toward +inf, zero divisor taken as one
    function automatic t_acc scale_to_q524(logic signed [RAW_W-1:0] raw,
                                           logic [SCALE_W-1:0] scale);
        t_acc div;
        t_acc rw;
        div = scale;
        if (scale == '0) div = 1;
        rw = raw;
        return clamp(floor_div((rw <<< (SC_FRAC + 1)) + div, 2 * div), SC_MIN, SC_MAX);
    endfunction

    // work value times Q5.24, rounded back to the work fraction
    function automatic t_acc mul_round_q24(t_acc a, t_acc s);
        return (a * s + (t_acc'(1) <<< (SC_FRAC - 1))) >>> SC_FRAC;
    endfunction

    function automatic t_reading compensate_reading(logic signed [RAW_W-1:0] rp,
                                                    logic signed [RAW_W-1:0] rt,
                                                    logic rdy);
        t_reading r;
        t_acc c0, c1, c00, c10, c01, c11, c20, c21, c30;
        t_acc psc, tsc, t1, t2, t3, u1, u2, p, t;
        if (!rdy) begin
            r.pressure    = PRESS_NOT_READY;
            r.temperature = TEMP_NOT_READY;
            r.valid       = 1'b0;
            return r;
        end
        c0  = $signed(coef_temp[23:12]);
        c1  = $signed(coef_temp[11:0]);
        c00 = $signed(coef_press_offset[39:20]);
        c10 = $signed(coef_press_offset[19:0]);
        c01 = $signed(coef_press_mid[47:32]);
        c11 = $signed(coef_press_mid[31:16]);
        c20 = $signed(coef_press_mid[15:0]);
        c21 = $signed(coef_press_high[31:16]);
        c30 = $signed(coef_press_high[15:0]);

        psc = scale_to_q524(rp, scale_press);
        tsc = scale_to_q524(rt, scale_temp);

        t1 = (c20 <<< PW_FRAC) + mul_round_q24(c30 <<< PW_FRAC, psc);
        t2 = (c10 <<< PW_FRAC) + mul_round_q24(t1, psc);
        t3 = (c00 <<< PW_FRAC) + mul_round_q24(t2, psc);
        u1 = (c11 <<< PW_FRAC) + mul_round_q24(c21 <<< PW_FRAC, psc);
        u2 = (c01 <<< PW_FRAC) + mul_round_q24(u1, psc);
        p  = (t3 + mul_round_q24(u2, tsc) + (t_acc'(1) <<< (P_SHIFT - 1))) >>> P_SHIFT;
        p  = clamp(p, PRESS_MIN, PRESS_MAX);

        t = (c0 <<< C0_SHIFT) + ((c1 * tsc + (t_acc'(1) <<< (T_SHIFT - 1))) >>> T_SHIFT);
        t = clamp(t, TEMP_MIN, TEMP_MAX);

        r.pressure    = p[PRESS_W-1:0];
        r.temperature = t[TEMP_W-1:0];
        r.valid       = 1'b1;
        return r;
    endfunction

    // ---------------------------------------------------------------- checking

    task automatic note_fault(input string msg);
        fault_count++;
        if (fault_count <= MAX_REPORTS) $display("ERROR @%0t: %s", $time, msg);
    endtask

    always @(negedge clk) begin
        result_ready = ($urandom_range(99) >= recv_stall_pct);
    end

    always @(posedge clk) begin
        t_reading want;
        if (rst_n) begin
            if (reading_valid && reading_accept)
                pending_readings.push_back(compensate_reading(raw_press, raw_temp, reading_rdy));
            if (result_out_valid && result_ready) begin
                if (pending_readings.size() == 0) begin
                    note_fault("result beat with no reading outstanding");
                end else begin
                    want = pending_readings.pop_front();
                    if (press_out !== want.pressure || temp_out !== want.temperature ||
                        result_flag !== want.valid)
                        note_fault($sformatf(
                            "pressure exp %0d got %0d, temp exp %0d got %0d, valid exp %0b got %0b",
                            want.pressure, press_out, want.temperature, temp_out,
                            want.valid, result_flag));
                end
            end
        end
    end

    // ---------------------------------------------------------------- drivers

    // all driving tasks start and end just after a falling edge
    task automatic send_reading(input logic signed [RAW_W-1:0] rp,
                                input logic signed [RAW_W-1:0] rt, input logic rdy);
        while ($urandom_range(99) < send_idle_pct) begin
            reading_valid = 1'b0;
            @(negedge clk);
        end
        reading_valid = 1'b1;
        raw_press     = rp;
        raw_temp      = rt;
        reading_rdy   = rdy;
        @(posedge clk);
        while (!reading_accept) @(posedge clk);
        @(negedge clk);
    endtask

    task automatic wait_drain();
        reading_valid = 1'b0;
        while (pending_readings.size() != 0) @(negedge clk);
        repeat (4) @(negedge clk);
    endtask

    task automatic cfg_write(input logic [CFG_IDX_W-1:0] idx, input logic [CFG_W-1:0] data);
        cfg_we   = 1'b1;
        cfg_idx  = idx;
        cfg_data = data;
        @(posedge clk);
        case (idx)
            CFG_TEMP_COEF:    coef_temp         = data[TCOEF_W-1:0];
            CFG_PRESS_OFFSET: coef_press_offset = data[POFF_W-1:0];
            CFG_PRESS_MID:    coef_press_mid    = data[PMID_W-1:0];
            CFG_PRESS_HIGH:   coef_press_high   = data[PHIGH_W-1:0];
            CFG_TEMP_SCALE:   scale_temp        = data[SCALE_W-1:0];
            CFG_PRESS_SCALE:  scale_press       = data[SCALE_W-1:0];
            default: ;
        endcase
        @(negedge clk);
        cfg_we = 1'b0;
    endtask

    task automatic load_calibration(input logic [CFG_W-1:0] tc, input logic [CFG_W-1:0] po,
                                    input logic [CFG_W-1:0] pm, input logic [CFG_W-1:0] ph,
                                    input logic [CFG_W-1:0] ts, input logic [CFG_W-1:0] ps);
        wait_drain();
        cfg_write(CFG_TEMP_COEF, tc);
        cfg_write(CFG_PRESS_OFFSET, po);
        cfg_write(CFG_PRESS_MID, pm);
        cfg_write(CFG_PRESS_HIGH, ph);
        cfg_write(CFG_TEMP_SCALE, ts);
        cfg_write(CFG_PRESS_SCALE, ps);
    endtask

    // ---------------------------------------------------------------- random values

    function automatic logic [CFG_W-1:0] rand_word();
        logic [63:0] v;
        v = {$urandom, $urandom};
        case ($urandom_range(0, 7))
            0: return '0;
            1: return '1;
            default: return v[CFG_W-1:0];
        endcase
    endfunction

    function automatic logic [CFG_W-1:0] rand_scale();
        logic [63:0] v;
        v = {$urandom, $urandom};
        case ($urandom_range(0, 7))
            0: return '0;
            1: return 1;
            2: return SCALE_MAX;
            3: return v[CFG_W-1:0];   // upper bits beyond the register are dropped
            4, 5: return OSR_SCALES[$urandom_range(0, 7)];
            default: return $urandom_range(1, SCALE_MAX);
        endcase
    endfunction

    function automatic logic signed [RAW_W-1:0] rand_raw();
        logic [31:0] v;
        v = $urandom;
        case ($urandom_range(0, 9))
            0: begin
                case ($urandom_range(0, 3))
                    0: return RAW_MAX;
                    1: return RAW_MIN;
                    2: return '0;
                    default: return '1;
                endcase
            end
            1: return $signed(v[RAW_W-1:0]) >>> 12;
            default: return v[RAW_W-1:0];
        endcase
    endfunction

    // ---------------------------------------------------------------- tests

    task automatic test_not_ready();
        send_reading(0, 0, 1'b0);
        send_reading(RAW_MAX, RAW_MIN, 1'b0);
        send_reading(RAW_MIN, RAW_MAX, 1'b0);
    endtask

    task automatic test_reset_calibration();
        send_reading(0, 0, 1'b1);
        send_reading(RAW_MAX, RAW_MAX, 1'b1);
        send_reading(RAW_MIN, RAW_MIN, 1'b1);
    endtask

    task automatic test_coefficient_extremes();
        // every coefficient -1, unit divisors push both scaled raws of the full-scale readings into saturation
        load_calibration('1, '1, '1, '1, 1, 1);
        send_reading(RAW_MAX, RAW_MAX, 1'b1);
        send_reading(RAW_MIN, RAW_MIN, 1'b1);
        send_reading(1, -1, 1'b1);
        // largest positive coefficients, zero pressure divisor
        load_calibration(48'h7FF7FF, 48'h7FFFF7FFFF, 48'h7FFF7FFF7FFF, 48'h7FFF7FFF,
                         SCALE_MAX, 0);
        send_reading(RAW_MAX, RAW_MIN, 1'b1);
        send_reading(RAW_MIN, RAW_MAX, 1'b1);
        send_reading(0, 0, 1'b1);
        // most negative coefficients, largest divisors
        load_calibration(48'h800800, 48'h8000080000, 48'h800080008000, 48'h80008000,
                         SCALE_MAX, SCALE_MAX);
        send_reading(RAW_MAX, RAW_MAX, 1'b1);
        send_reading(RAW_MIN, RAW_MIN, 1'b1);
        send_reading(-1, 1, 1'b1);
        send_reading(1, 0, 1'b1);
    endtask

    task automatic test_spare_index();
        load_calibration(48'h123456, 48'h0123456789, 48'h3456789ABCDE, 48'h13579BDF,
                         OSR_SCALES[3], OSR_SCALES[6]);
        cfg_write(CFG_IDX_SPARE_A, '1);
        cfg_write(CFG_IDX_SPARE_B, '1);
        send_reading(RAW_MAX >>> 3, RAW_MIN >>> 3, 1'b1);
        send_reading(12345, -6789, 1'b1);
    endtask

    task automatic test_random_traffic(input int idle_pct, input int stall_pct,
                                       input int n_items);
        send_idle_pct  = idle_pct;
        recv_stall_pct = stall_pct;
        for (int k = 0; k < n_items; k++) begin
            if (k % 125 == 0)
                load_calibration(rand_word(), rand_word(), rand_word(), rand_word(),
                                 rand_scale(), rand_scale());
            // sender holds off until the pipe has emptied
            if (k == 60) wait_drain();
            send_reading(rand_raw(), rand_raw(), $urandom_range(0, 9) != 0);
        end
    endtask

    initial begin
        rst_n         = 1'b0;
        cfg_we        = 1'b0;
        cfg_idx       = CFG_TEMP_COEF;
        cfg_data      = '0;
        reading_valid = 1'b0;
        raw_press     = '0;
        raw_temp      = '0;
        reading_rdy   = 1'b0;

        coef_temp         = '0;
        coef_press_offset = '0;
        coef_press_mid    = '0;
        coef_press_high   = '0;
        scale_temp        = SCALE_RST;
        scale_press       = SCALE_RST;

        repeat (7) @(posedge clk);
        @(negedge clk);
        rst_n = 1'b1;

        test_not_ready();
        test_reset_calibration();
        test_coefficient_extremes();
        test_spare_index();

        test_random_traffic(0, 0, 245);
        test_random_traffic(65, 0, 245);
        test_random_traffic(0, 65, 245);
        test_random_traffic(37, 37, 245);

        reading_valid = 1'b0;
        while (pending_readings.size() != 0) @(negedge clk);
        repeat (DRAIN_WAIT) @(posedge clk);

        if (fault_count == 0) begin
            $display("Test completed successfully");
        end else begin
            $display("Test completed with failures");
        end
        $finish;
    end

endmodule
